FILE: rtl/khash_pkg.sv
`timescale 1ns / 1ps

package khash_pkg;

   localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
   localparam logic [7:0]  OPEN_BRACE  = 8'h7B;
   localparam logic [7:0]  CLOSE_BRACE = 8'h7D;
   localparam int          SLOT_FIELD_WIDTH = 10;

   typedef enum logic [1:0] {
      PHASE_BEFORE = 2'd0,
      PHASE_INSIDE = 2'd1,
      PHASE_CLOSED = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] key_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [SLOT_FIELD_WIDTH-1:0] slot_number;
      logic [31:0]                 crc_value;
      logic                        has_tag;
   } rsp_type;

   // one classified byte passed from the front to the back
   typedef struct packed {
      logic [7:0] key_byte;
      logic       last_byte;
      logic       tag_feed;
      logic       has_tag;
   } entry_type;

   // reflected crc-32, one byte, eight bit steps
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                            input logic [7:0]  data);
      logic [31:0] r;
      r = crc_in ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

FILE: rtl/khash_front.sv
`timescale 1ns / 1ps

module khash_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  khash_pkg::req_type   req_data,
   output logic                 push_valid,
   input  logic                 push_ready,
   output khash_pkg::entry_type push_data
);
   import khash_pkg::*;

   phase_type phase_ff;
   phase_type phase_in;
   phase_type phase_step;
   logic      tag_feed;
   logic      accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_BEFORE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      phase_step = phase_ff;
      tag_feed   = 1'b0;
      unique case (phase_ff)
         PHASE_BEFORE: begin
            if (req_data.key_byte == OPEN_BRACE) begin
               phase_step = PHASE_INSIDE;
            end
         end
         PHASE_INSIDE: begin
            if (req_data.key_byte == CLOSE_BRACE) begin
               phase_step = PHASE_CLOSED;
            end else begin
               tag_feed = 1'b1;
            end
         end
         PHASE_CLOSED: begin
            phase_step = PHASE_CLOSED;
         end
         default: begin
            phase_step = PHASE_BEFORE;
         end
      endcase

      // a key ends on its last word, the next one starts before any brace
      phase_in = phase_ff;
      if (accept) begin
         phase_in = req_data.last_byte ? PHASE_BEFORE : phase_step;
      end

      push_data.key_byte  = req_data.key_byte;
      push_data.last_byte = req_data.last_byte;
      push_data.tag_feed  = tag_feed;
      push_data.has_tag   = (phase_step == PHASE_CLOSED);
   end

endmodule

FILE: rtl/khash_fifo.sv
`timescale 1ns / 1ps

module khash_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  khash_pkg::entry_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output khash_pkg::entry_type pop_data
);
   import khash_pkg::*;

   entry_type  store_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/khash_back.sv
`timescale 1ns / 1ps

module khash_back #(
   parameter int SLOT_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  khash_pkg::entry_type pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output khash_pkg::rsp_type   rsp_data
);
   import khash_pkg::*;

   localparam logic [31:0] SlotMask = (SLOT_BITS >= 32) ? 32'hFFFF_FFFF
                                      : ((32'd1 << SLOT_BITS) - 32'd1);

   logic [31:0] whole_crc_ff;
   logic [31:0] whole_crc_in;
   logic [31:0] tag_crc_ff;
   logic [31:0] tag_crc_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;
   logic [31:0] whole_next;
   logic [31:0] tag_next;
   logic [31:0] final_crc;
   logic [31:0] slot_wide;
   logic        do_pop;

   // only a last word needs room in the output register
   assign pop_ready = !pop_data.last_byte || !rsp_valid_ff || rsp_ready;
   assign do_pop    = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      whole_next = crc_byte(whole_crc_ff, pop_data.key_byte);
      tag_next   = pop_data.tag_feed ? crc_byte(tag_crc_ff, pop_data.key_byte)
                                     : tag_crc_ff;
      final_crc  = pop_data.has_tag ? ~tag_next : ~whole_next;
      slot_wide  = final_crc & SlotMask;

      rsp_data_in.slot_number = slot_wide[SLOT_FIELD_WIDTH-1:0];
      rsp_data_in.crc_value   = final_crc;
      rsp_data_in.has_tag     = pop_data.has_tag;

      whole_crc_in = whole_crc_ff;
      tag_crc_in   = tag_crc_ff;
      if (do_pop) begin
         whole_crc_in = pop_data.last_byte ? CRC_INIT : whole_next;
         tag_crc_in   = pop_data.last_byte ? CRC_INIT : tag_next;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (do_pop && pop_data.last_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_crc_ff <= CRC_INIT;
         tag_crc_ff   <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         whole_crc_ff <= whole_crc_in;
         tag_crc_ff   <= tag_crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop && pop_data.last_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: rtl/key_slot_hash_with_tag.sv
`timescale 1ns / 1ps
// path: the last key byte is written into the queue, then its result is taken into the output register and shows on rsp
// throughput: one key byte per cycle while rsp is taken, set by the combinational byte crc in the back end
// a two-word queue parts brace tracking from the crc, the output register holds one result
// reset (synchronous): brace phase, queue, both crcs (to all ones) and rsp_valid cleared

module key_slot_hash_with_tag #(
   parameter int SLOT_BITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  khash_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output khash_pkg::rsp_type rsp_data
);
   import khash_pkg::*;

   entry_type push_data;
   entry_type pop_data;
   logic      push_valid;
   logic      push_ready;
   logic      pop_valid;
   logic      pop_ready;

   khash_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   khash_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   khash_back #(
      .SLOT_BITS (SLOT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
